/* rtl/serial_command_slave_macros.svh */
// Assertion helpers for the serial command slave.
`ifndef SERIAL_COMMAND_SLAVE_MACROS_SVH
`define SERIAL_COMMAND_SLAVE_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define SCS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("serial_command_slave: check failed");

// Antecedent implies consequent in the next cycle.
`define SCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("serial_command_slave: check failed");

`else

`define SCS_ASSERT_SAME(label, clk, rst, ante, cons)
`define SCS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/scs_pkg.sv */
`default_nettype none

package scs_pkg;

  localparam int FRAME_BYTES = 6;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);

  localparam logic [7:0] CMD_HELLO   = 8'h00;
  localparam logic [7:0] CMD_RED     = 8'h10;
  localparam logic [7:0] CMD_YELLOW  = 8'h12;
  localparam logic [7:0] CMD_BUTTON1 = 8'h30;
  localparam logic [7:0] CMD_BUTTON2 = 8'h32;
  localparam logic [7:0] CMD_LOAD    = 8'h40;
  localparam logic [7:0] CMD_TEMP    = 8'h42;

  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic                        red;
    logic                        yellow;
  } reply_t;

endpackage

`default_nettype wire

/* rtl/scs_tx.sv */
`default_nettype none

module scs_tx (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire scs_pkg::reply_t reply,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output logic [7:0]           tx_byte,
  output logic                 last_byte,
  output logic                 red_led,
  output logic                 yellow_led
);

  logic [scs_pkg::FRAME_BYTES-1:0][7:0] bytes;
  logic [scs_pkg::COUNT_W-1:0]          beats_left;
  logic                                 out_fire;

  assign out_valid  = (beats_left != '0);
  assign out_fire   = out_valid && out_ready;
  assign tx_byte    = bytes[0];
  assign last_byte  = (beats_left == scs_pkg::COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      beats_left <= '0;
    end else if (load) begin
      beats_left <= scs_pkg::COUNT_W'(scs_pkg::FRAME_BYTES);
    end else if (out_fire) begin
      beats_left <= beats_left - scs_pkg::COUNT_W'(1);
    end
  end

  // reply shifts down one byte per beat
  always_ff @(posedge clk) begin
    if (load) begin
      bytes      <= reply.bytes;
      red_led    <= reply.red;
      yellow_led <= reply.yellow;
    end else if (out_fire) begin
      bytes <= {8'h00, bytes[scs_pkg::FRAME_BYTES-1:1]};
    end
  end

endmodule

`default_nettype wire

/* rtl/serial_command_slave.sv */
// Channel  Handshake              Payload
// in       in_valid / in_ready    action, rx_byte, button levels, cpu load and temp
// out      out_valid / out_ready  tx_byte, last_byte, red_led, yellow_led
// cfg      cfg_valid / cfg_ready  cfg_data (device_id)
//
// One input beat per cycle; a beat that completes a good frame starts a
// six-beat reply on the next cycle, one byte per cycle when out_ready is high.
// The reply buffer drains while new frame bytes keep arriving; only the
// sixth byte of the next frame (or a timeout at that point) waits for it.
// rst is synchronous: clears frame position, sum, LED state and device_id.
// cfg_ready is always high. The red_led and yellow_led outputs are not reset.
`default_nettype none

`include "serial_command_slave_macros.svh"

module serial_command_slave (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       action,
  input  wire logic [7:0] rx_byte,
  input  wire logic       button_one_level,
  input  wire logic       button_two_level,
  input  wire logic [7:0] cpu_load_value,
  input  wire logic [7:0] cpu_temp_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      tx_byte,
  output logic            last_byte,
  output logic            red_led,
  output logic            yellow_led,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  localparam logic [scs_pkg::POS_W-1:0] LAST_POS = scs_pkg::POS_W'(scs_pkg::FRAME_BYTES - 1);

  logic [7:0]                frame_store [scs_pkg::FRAME_BYTES-1];
  logic [scs_pkg::POS_W-1:0] byte_position;
  logic [7:0]                running_sum;
  logic                      red_on;
  logic                      yellow_on;
  logic                      red_next;
  logic                      yellow_next;
  logic [7:0]                device_id;

  logic            in_fire;
  logic            at_last;
  logic            frame_ok;
  logic            known;
  logic [7:0]      data;
  logic            load;
  scs_pkg::reply_t reply;

  assign cfg_ready = 1'b1;
  assign at_last   = (byte_position == LAST_POS);
  assign in_ready  = !at_last || !out_valid;
  assign in_fire   = in_valid && in_ready;
  assign frame_ok  = (rx_byte == running_sum) && (frame_store[1] == device_id);

  always_comb begin
    known       = 1'b1;
    data        = 8'h00;
    red_next    = red_on;
    yellow_next = yellow_on;
    case (frame_store[2])
      scs_pkg::CMD_HELLO:   data = 8'h00;
      scs_pkg::CMD_RED:     red_next = (frame_store[4] != 8'h00);
      scs_pkg::CMD_YELLOW:  yellow_next = (frame_store[4] != 8'h00);
      scs_pkg::CMD_BUTTON1: data = {7'd0, !button_one_level};
      scs_pkg::CMD_BUTTON2: data = {7'd0, !button_two_level};
      scs_pkg::CMD_LOAD:    data = cpu_load_value;
      scs_pkg::CMD_TEMP:    data = cpu_temp_value;
      default:              known = 1'b0;
    endcase
  end

  assign load = in_fire && !action && at_last && frame_ok && known;

  always_comb begin
    reply.bytes[0] = frame_store[1];
    reply.bytes[1] = frame_store[0];
    reply.bytes[2] = frame_store[2] + 8'd1;
    reply.bytes[3] = 8'h00;
    reply.bytes[4] = data;
    reply.bytes[5] = frame_store[1] + frame_store[0] + frame_store[2] + 8'd1 + data;
    reply.red      = red_next;
    reply.yellow   = yellow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= '0;
      red_on        <= 1'b0;
      yellow_on     <= 1'b0;
      device_id     <= '0;
    end else begin
      if (cfg_valid) begin
        device_id <= cfg_data;
      end
      if (in_fire) begin
        if (action || at_last) begin
          byte_position <= '0;
          running_sum   <= '0;
        end else begin
          byte_position <= byte_position + scs_pkg::POS_W'(1);
          running_sum   <= running_sum + rx_byte;
        end
        if (load) begin
          red_on    <= red_next;
          yellow_on <= yellow_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !action && !at_last) begin
      frame_store[byte_position] <= rx_byte;
    end
  end

  scs_tx u_tx (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .reply      (reply),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .tx_byte    (tx_byte),
    .last_byte  (last_byte),
    .red_led    (red_led),
    .yellow_led (yellow_led)
  );

  // the closing byte of a frame only enters with the reply buffer empty
  `SCS_ASSERT_SAME(a_close_needs_free_buf, clk, rst, in_fire && at_last, !out_valid)
  // after the last beat the buffer is empty
  `SCS_ASSERT_NEXT(a_last_empties, clk, rst, out_valid && out_ready && last_byte, !out_valid)
  // position never runs past the closing byte
  `SCS_ASSERT_SAME(a_pos_range, clk, rst, 1'b1, byte_position <= LAST_POS)

endmodule

`default_nettype wire

/* dv/serial_command_slave_test.sv */
`default_nettype none

module serial_command_slave_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   SETTLE_CYCLES  = 10;
  localparam int   TARGET_BYTES   = 400;

  localparam logic [7:0] KNOWN_CMDS [0:6] = '{scs_pkg::CMD_HELLO, scs_pkg::CMD_RED,
    scs_pkg::CMD_YELLOW, scs_pkg::CMD_BUTTON1, scs_pkg::CMD_BUTTON2, scs_pkg::CMD_LOAD,
    scs_pkg::CMD_TEMP};

  typedef struct {
    logic [7:0] tx;
    logic       last;
    logic       red;
    logic       yellow;
  } reply_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       action = ACT_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic       button_one_level = 1'b1;
  logic       button_two_level = 1'b1;
  logic [7:0] cpu_load_value = 8'h00;
  logic [7:0] cpu_temp_value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic       red_led;
  logic       yellow_led;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  // frame receiver mirror
  logic [7:0] rx_hold [0:scs_pkg::FRAME_BYTES-2];
  int         rx_count = 0;
  logic [7:0] rx_sum = 8'h00;
  logic       led_red = 1'b0;
  logic       led_yellow = 1'b0;
  logic [7:0] my_address = 8'h00;

  reply_beat_t reply_q [$];

  int  errors = 0;
  int  byte_items = 0;
  int  timeout_items = 0;
  int  replies_seen = 0;
  int  beats_seen = 0;
  int  address_writes = 0;
  int  in_gap = 0;
  int  out_wait = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;

  serial_command_slave DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .rx_byte          (rx_byte),
    .button_one_level (button_one_level),
    .button_two_level (button_two_level),
    .cpu_load_value   (cpu_load_value),
    .cpu_temp_value   (cpu_temp_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .tx_byte          (tx_byte),
    .last_byte        (last_byte),
    .red_led          (red_led),
    .yellow_led       (yellow_led),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_wait();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // Advance the receiver mirror by one input beat; queue the reply if a good frame closes.
  task automatic predict_reply(input logic act, input logic [7:0] rx, input logic b1,
                               input logic b2, input logic [7:0] load, input logic [7:0] temp);
    logic [7:0]  reply [0:scs_pkg::FRAME_BYTES-1];
    logic [7:0]  value;
    logic        good;
    reply_beat_t beat;
    begin
      if (act == ACT_TIMEOUT) begin
        rx_count = 0;
        rx_sum = 8'h00;
        return;
      end
      if (rx_count < scs_pkg::FRAME_BYTES - 1) begin
        rx_hold[3'(rx_count)] = rx;
        rx_sum = rx_sum + rx;
        rx_count++;
        return;
      end
      good = (rx == rx_sum) && (rx_hold[1] == my_address);
      rx_count = 0;
      rx_sum = 8'h00;
      if (!good) return;
      case (rx_hold[2])
        scs_pkg::CMD_HELLO:   value = 8'h00;
        scs_pkg::CMD_RED: begin
          led_red = (rx_hold[4] != 8'h00);
          value = 8'h00;
        end
        scs_pkg::CMD_YELLOW: begin
          led_yellow = (rx_hold[4] != 8'h00);
          value = 8'h00;
        end
        scs_pkg::CMD_BUTTON1: value = {7'd0, ~b1};
        scs_pkg::CMD_BUTTON2: value = {7'd0, ~b2};
        scs_pkg::CMD_LOAD:    value = load;
        scs_pkg::CMD_TEMP:    value = temp;
        default:              return;
      endcase
      reply[0] = rx_hold[1];
      reply[1] = rx_hold[0];
      reply[2] = rx_hold[2] + 8'd1;
      reply[3] = 8'h00;
      reply[4] = value;
      reply[5] = reply[0] + reply[1] + reply[2] + reply[3] + reply[4];
      for (int k = 0; k < scs_pkg::FRAME_BYTES; k++) begin
        beat.tx = reply[k];
        beat.last = (k == scs_pkg::FRAME_BYTES - 1);
        beat.red = led_red;
        beat.yellow = led_yellow;
        reply_q.push_back(beat);
      end
    end
  endtask

  // valid is left high across back-to-back beats; it is lowered only when a gap follows
  task automatic send_item(input logic act, input logic [7:0] rx, input logic b1,
                           input logic b2, input logic [7:0] load, input logic [7:0] temp);
    if (in_gap > 0) repeat (in_gap) @(posedge clk);
    in_valid <= 1'b1;
    action <= act;
    rx_byte <= rx;
    button_one_level <= b1;
    button_two_level <= b2;
    cpu_load_value <= load;
    cpu_temp_value <= temp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_reply(act, rx, b1, b2, load, temp);
    if (act == ACT_TIMEOUT) timeout_items++;
    else byte_items++;
    if ($urandom_range(0, 29) == 0) calm = ~calm;
    in_gap = pick_wait();
    if (in_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic act, input logic [7:0] rx);
    send_item(act, rx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic flush_input();
    if (in_gap == 0) in_valid <= 1'b0;
    in_gap = 0;
  endtask

  task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                            input logic [7:0] cmd, input logic [7:0] b3,
                            input logic [7:0] dat, input logic [7:0] sum_flip,
                            input logic b1, input logic b2,
                            input logic [7:0] load, input logic [7:0] temp);
    logic [7:0] s;
    begin
      s = src + dst + cmd + b3 + dat;
      send_byte(ACT_BYTE, src);
      send_byte(ACT_BYTE, dst);
      send_byte(ACT_BYTE, cmd);
      send_byte(ACT_BYTE, b3);
      send_byte(ACT_BYTE, dat);
      send_item(ACT_BYTE, s ^ sum_flip, b1, b2, load, temp);
    end
  endtask

  // Mostly well-formed frames; some with bad address, bad sum, unknown command or cut short.
  task automatic send_random_frame();
    logic [7:0] f [0:4];
    logic [7:0] flip;
    int         cut;
    begin
      if (rx_count != 0 && $urandom_range(0, 9) != 0)
        send_byte(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
      f[0] = 8'($urandom_range(0, 255));
      f[1] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : my_address;
      f[2] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : KNOWN_CMDS[3'($urandom_range(0, 6))];
      f[3] = 8'($urandom_range(0, 255));
      f[4] = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      if ($urandom_range(0, 11) == 0) begin
        cut = $urandom_range(1, 5);
        for (int i = 0; i < cut; i++) send_byte(ACT_BYTE, f[i]);
        send_byte(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
      end else begin
        send_frame(f[0], f[1], f[2], f[3], f[4], flip,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Address changes only with the receiver empty and the reply path drained.
  task automatic set_device_id(input logic [7:0] id);
    if (rx_count != 0) send_byte(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
    flush_input();
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= id;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    my_address = id;
    address_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_frames();
    // device_id still at its reset value of zero
    send_frame(8'hFF, 8'h00, scs_pkg::CMD_HELLO, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1, 8'h00, 8'h00);
    send_frame(8'h00, 8'h00, scs_pkg::CMD_TEMP, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'hFF, 8'hFF);
    // corrupted sum: consumed, no reply
    send_frame(8'h5A, 8'h00, scs_pkg::CMD_HELLO, 8'h00, 8'h00, 8'h01, 1'b0, 1'b1, 8'h80, 8'h7F);
    // partial frame thrown away by a timeout
    send_byte(ACT_BYTE, 8'h00);
    send_byte(ACT_BYTE, 8'hFF);
    send_byte(ACT_BYTE, 8'hAA);
    send_byte(ACT_TIMEOUT, 8'hFF);
    // unknown command: no reply
    send_frame(8'h01, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 1'b1, 1'b0, 8'h7F, 8'h80);
  endtask

  task automatic test_address_extremes();
    set_device_id(8'hFF);
    repeat (12) send_random_frame();
    set_device_id(8'h00);
    repeat (12) send_random_frame();
  endtask

  task automatic test_random_traffic();
    repeat (3) begin
      set_device_id(8'($urandom_range(0, 255)));
      repeat (10) send_random_frame();
    end
  endtask

  // stray bytes knock the receiver out of frame alignment
  task automatic test_noise();
    set_device_id(8'($urandom_range(1, 254)));
    while (byte_items < TARGET_BYTES) begin
      if ($urandom_range(0, 3) == 0) send_byte(ACT_BYTE, 8'($urandom_range(0, 255)));
      else send_random_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    reply_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_wait = 0;
    end else if (out_valid && out_ready) begin
      beats_seen++;
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected reply beat, expected none actual tx_byte %02h",
                 $time, tx_byte);
        errors++;
      end else begin
        want = reply_q.pop_front();
        check_field("tx_byte", want.tx, tx_byte);
        check_field("last_byte", 8'(want.last), 8'(last_byte));
        check_field("red_led", 8'(want.red), 8'(red_led));
        check_field("yellow_led", 8'(want.yellow), 8'(yellow_led));
        if (want.last) replies_seen++;
      end
      out_wait = pick_wait();
      if (out_wait > 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (out_wait > 0) out_wait--;
      if (out_wait == 0) out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_address_extremes();
    test_random_traffic();
    test_noise();
    flush_input();
    while (reply_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d frame bytes and %0d timeouts over %0d device_id settings",
             byte_items, timeout_items, address_writes + 1);
    $display("Checked %0d reply beats in %0d complete replies", beats_seen, replies_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
